// ===== hw/rtl/u8bd_pkg.sv =====
package u8bd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int BYTE_W         = 8;
  localparam int CP_W           = 16;
  localparam int SHOWN_W        = 16;
  localparam int PARTIAL_W      = 10;

  // Lead byte classes
  localparam logic [7:0] ASCII_MASK  = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'he0;
  localparam logic [7:0] LEAD2_CODE  = 8'hc0;
  localparam logic [7:0] LEAD3_MASK  = 8'hf0;
  localparam logic [7:0] LEAD3_CODE  = 8'he0;
  localparam logic [7:0] LEAD2_BITS  = 8'h1f;
  localparam logic [7:0] LEAD3_BITS  = 8'h0f;
  localparam logic [7:0] CONT_BITS   = 8'h3f;
  localparam logic [SHOWN_W-1:0] SHOWN_MAX = 16'hffff;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_END      = 2'd1,
    ST_BAD_LEAD = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    status_t            status;
    logic [SHOWN_W-1:0] char_count;
    logic               end_of_string;
  } result_t;

  // Handshake between input stage and decoder
  typedef struct packed {
    logic              step;
    logic [BYTE_W-1:0] text_byte;
  } step_t;

endpackage

// ===== hw/rtl/utf8_bmp_stream_decoder.sv =====
// Channel | Dir | Ports                       | Contents
// in_     | in  | tvalid tready tdata[7:0]    | raw string byte, zero ends the string
// out_    | out | tvalid tready tdata[31:0]   | code point, saturated char count
//         |     | tuser[1:0] tlast            | status, last word of the string
//
// One byte per clock sustained while out_tready stays high; an accepted byte is
// held in the input register, then decoded into the result register.
// A byte that yields no result (lead or middle byte, bytes after an error)
// still takes one slot in the decode stage.
// Reset: synchronous, active low; clears decode state and both valid flags.
// Stalls: out_tready low holds the result register; the input register then
// fills and in_tready drops after one more word.
module utf8_bmp_stream_decoder
  import u8bd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] code_point, [31:16] char_count
  output logic [1:0]  out_tuser,   // [1:0] status
  output logic        out_tlast    // end_of_string
);

  step_t   step;
  logic    res_vld;
  result_t res;
  result_t res_q;
  logic    out_free;
  logic    load;

  u8bd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .dn_free   (out_free),
    .step_o    (step)
  );

  // decode state advances only when the result slot can take the outcome
  u8bd_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .res_vld (res_vld),
    .res     (res)
  );

  assign load = step.step & res_vld;

  u8bd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res_i      (res),
    .up_free    (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_o      (res_q)
  );

  assign out_tdata = {res_q.char_count, res_q.code_point};
  assign out_tuser = res_q.status;
  assign out_tlast = res_q.end_of_string;

  // A decode step never overruns a held result.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    step.step |-> (!out_tvalid || out_tready))
    else $error("decode step while result register is blocked");

  // Character words never carry tlast; every other status does.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ST_CHAR) == !out_tlast))
    else $error("tlast does not match status");

  // Result valid rises only after a decode step that produced a result.
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(load))
    else $error("result appeared without a decode step");

  // Non-char results have a zero code point.
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[15:0] == '0))
    else $error("end word carries a code point");

endmodule

// ===== hw/rtl/u8bd_in_stage.sv =====
module u8bd_in_stage
  import u8bd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  input  logic              dn_free,   // decoder may take a word this cycle
  output step_t             step_o
);

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              adv;

  assign adv       = vld_r & dn_free;
  assign in_tready = ~vld_r | adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_tvalid && in_tready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign step_o.step      = adv;
  assign step_o.text_byte = byte_r;

endmodule

// ===== hw/rtl/u8bd_core.sv =====
module u8bd_core
  import u8bd_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  step_t   step_i,
  output logic    res_vld,
  output result_t res
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [1:0]            pend_r, pend_nxt;
  logic [PARTIAL_W-1:0]  part_r, part_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  halt_r, halt_nxt;

  logic [BYTE_W-1:0]     b;
  logic [CP_W-1:0]       joined;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_show_src;
  logic [SHOWN_W-1:0]    cnt_shown;
  logic                  is_char;

  assign b       = step_i.text_byte;
  assign joined  = {part_r, b[5:0] & CONT_BITS[5:0]};
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  // byte completes a char: last continuation, or plain byte at a boundary
  assign is_char = (b != '0) & ~halt_r &
                   ((pend_r == 2'd1) | ((pend_r == 2'd0) & ((b & ASCII_MASK) == '0)));

  // char results show the count including this char
  assign cnt_show_src = is_char ? cnt_inc : cnt_r;

  generate
    if (COUNT_BITS > SHOWN_W) begin : g_sat
      assign cnt_shown = (|cnt_show_src[COUNT_BITS-1:SHOWN_W]) ? SHOWN_MAX
                                                               : cnt_show_src[SHOWN_W-1:0];
    end else if (COUNT_BITS == SHOWN_W) begin : g_eq
      assign cnt_shown = cnt_show_src;
    end else begin : g_ext
      assign cnt_shown = {{(SHOWN_W-COUNT_BITS){1'b0}}, cnt_show_src};
    end
  endgenerate

  always_comb begin
    pend_nxt              = pend_r;
    part_nxt              = part_r;
    cnt_nxt               = cnt_r;
    halt_nxt              = halt_r;
    res_vld               = 1'b0;
    res.code_point        = '0;
    res.status            = ST_CHAR;
    res.char_count        = cnt_shown;
    res.end_of_string     = 1'b0;
    if (step_i.step) begin
      priority if (b == '0) begin
        // terminator: end or truncation, silent after an error
        res_vld           = ~halt_r;
        res.status        = (pend_r != 2'd0) ? ST_TRUNC : ST_END;
        res.end_of_string = 1'b1;
        pend_nxt          = '0;
        part_nxt          = '0;
        cnt_nxt           = '0;
        halt_nxt          = 1'b0;
      end else if (halt_r) begin
        res_vld = 1'b0;
      end else if (pend_r != 2'd0) begin
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          part_nxt       = '0;
          res_vld        = 1'b1;
          res.code_point = joined;
          cnt_nxt        = cnt_inc;
        end else begin
          part_nxt = joined[PARTIAL_W-1:0];
        end
      end else if ((b & ASCII_MASK) == '0) begin
        res_vld        = 1'b1;
        res.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
        cnt_nxt        = cnt_inc;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        pend_nxt = 2'd1;
        part_nxt = {{(PARTIAL_W-BYTE_W){1'b0}}, b & LEAD2_BITS};
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        pend_nxt = 2'd2;
        part_nxt = {{(PARTIAL_W-BYTE_W){1'b0}}, b & LEAD3_BITS};
      end else begin
        res_vld           = 1'b1;
        res.status        = ST_BAD_LEAD;
        res.end_of_string = 1'b1;
        halt_nxt          = 1'b1;
        pend_nxt          = '0;
        part_nxt          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
      cnt_r  <= '0;
      halt_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== hw/rtl/u8bd_out_stage.sv =====
module u8bd_out_stage
  import u8bd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_i,
  output logic    up_free,     // result register can take a word
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t res_o
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign up_free = ~vld_r | out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

  assign out_tvalid = vld_r;
  assign res_o      = res_r;

endmodule

// ===== test/utf8_bmp_stream_decoder_tb.sv =====
module utf8_bmp_stream_decoder_tb;
  import u8bd_pkg::*;

  localparam int CYCLE_LIMIT  = 20_000;
  localparam int DRAIN_CYCLES = 8;      // margin for the input and result registers to empty
  localparam int RANDOM_WORDS = 650;
  localparam int IDLE_PCT     = 14;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  utf8_bmp_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder shadow state, mirrors what the block should hold
  logic [1:0]                dec_pending;
  logic [PARTIAL_W-1:0]      dec_partial;
  logic [COUNT_BITS_DEF-1:0] dec_count;
  logic                      dec_halted;

  result_t expected_chars[$];

  int tx_idle_pct = IDLE_PCT;
  int rx_idle_pct = IDLE_PCT;
  int cycle_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int mismatches = 0;

  function automatic void clear_decoder();
    dec_pending = '0;
    dec_partial = '0;
    dec_count   = '0;
    dec_halted  = 1'b0;
  endfunction

  function automatic logic [SHOWN_W-1:0] shown_count();
    if (dec_count > COUNT_BITS_DEF'(SHOWN_MAX))
      return SHOWN_MAX;
    return dec_count[SHOWN_W-1:0];
  endfunction

  // Result with the current count and the given fields
  function automatic void push_result(input logic [CP_W-1:0] cp, input status_t st,
                                      input logic eos);
    result_t r;
    r.code_point    = cp;
    r.status        = st;
    r.char_count    = shown_count();
    r.end_of_string = eos;
    expected_chars.push_back(r);
  endfunction

  function automatic void push_char(input logic [CP_W-1:0] cp);
    if (dec_count != {COUNT_BITS_DEF{1'b1}})
      dec_count = dec_count + 1'b1;
    push_result(cp, ST_CHAR, 1'b0);
  endfunction

  // One accepted byte through the shadow decoder
  function automatic void decode_byte(input logic [7:0] b);
    logic [CP_W-1:0] code;
    if (b == 8'h00) begin
      // terminator: silent after an error, else end or truncation word
      if (!dec_halted)
        push_result('0, (dec_pending != 0) ? ST_TRUNC : ST_END, 1'b1);
      clear_decoder();
    end else if (dec_halted) begin
      // bytes after an error are dropped
    end else if (dec_pending != 0) begin
      // continuation: low six bits only, top bits never checked
      code = {dec_partial, b[5:0]};
      dec_pending = dec_pending - 1'b1;
      if (dec_pending == 0) begin
        dec_partial = '0;
        push_char(code);
      end else begin
        dec_partial = code[PARTIAL_W-1:0];
      end
    end else if ((b & ASCII_MASK) == 8'h00) begin
      push_char({8'h00, b});
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      dec_pending = 2'd1;
      dec_partial = PARTIAL_W'(b & LEAD2_BITS);
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      dec_pending = 2'd2;
      dec_partial = PARTIAL_W'(b & LEAD3_BITS);
    end else begin
      // stray continuation or 4-byte lead and above
      push_result('0, ST_BAD_LEAD, 1'b1);
      dec_halted  = 1'b1;
      dec_pending = '0;
      dec_partial = '0;
    end
  endfunction

  // Send one byte; valid stays up into the next call unless that call idles
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    decode_byte(b);
  endtask

  // Stop sending until every expected word is back, then let the pipe empty
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly proper 10xxxxxx, sometimes any nonzero byte (not checked by design)
  task automatic send_cont();
    if ($urandom_range(99) < 85)
      send_byte(8'h80 | 8'($urandom_range(0, 63)));
    else
      send_byte(8'($urandom_range(1, 255)));
  endtask

  // Random character of one, two or three bytes
  task automatic send_char();
    int len;
    len = $urandom_range(1, 3);
    case (len)
      1: begin
        send_byte(8'($urandom_range(1, 127)));
      end
      2: begin
        send_byte(8'hc0 | 8'($urandom_range(0, 31)));
        send_cont();
      end
      default: begin
        send_byte(8'he0 | 8'($urandom_range(0, 15)));
        send_cont();
        send_cont();
      end
    endcase
  endtask

  task automatic send_bad_lead();
    if ($urandom_range(1) == 0)
      send_byte(8'h80 | 8'($urandom_range(0, 63)));
    else
      send_byte(8'hf0 | 8'($urandom_range(0, 15)));
  endtask

  // Result checker: compare each word leaving the block with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: cp=%04h st=%0d cnt=%0d last=%0b",
                   out_tdata[15:0], out_tuser, out_tdata[31:16], out_tlast);
      end else begin
        exp_r = expected_chars.pop_front();
        if (out_tdata[15:0] !== exp_r.code_point || out_tuser !== exp_r.status ||
            out_tdata[31:16] !== exp_r.char_count || out_tlast !== exp_r.end_of_string) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch cp/st/cnt/last: exp %04h/%0d/%0d/%0b got %04h/%0d/%0d/%0b",
                     exp_r.code_point, exp_r.status, exp_r.char_count,
                     exp_r.end_of_string,
                     out_tdata[15:0], out_tuser, out_tdata[31:16], out_tlast);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_chars.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Edge cases: extreme characters, each status, unchecked continuation, halt
  task automatic test_directed();
    send_byte(8'h00);                       // empty string
    wait_drain();
    send_byte(8'h01);
    send_byte(8'h7f);
    send_byte(8'hc2); send_byte(8'h80);     // U+0080
    send_byte(8'hdf); send_byte(8'hff);     // U+07FF, continuation top bits ignored
    send_byte(8'he0); send_byte(8'ha0); send_byte(8'h80);   // U+0800
    send_byte(8'hef); send_byte(8'hbf); send_byte(8'hbf);   // U+FFFF
    send_byte(8'h00);
    wait_drain();
    send_byte(8'h80); send_byte(8'h41); send_byte(8'h00);   // stray continuation, halt
    send_byte(8'hf0); send_byte(8'h00);                     // 4-byte lead
    send_byte(8'hff); send_byte(8'h00);
    wait_drain();
    send_byte(8'he1); send_byte(8'h00);                     // zero right after lead
    send_byte(8'he1); send_byte(8'h81); send_byte(8'h00);   // zero mid sequence
    wait_drain();
  endtask

  // Random strings, mostly well-formed, with truncation, bad leads and noise
  task automatic test_random_strings();
    int pick;
    int n;
    while (words_sent < RANDOM_WORDS) begin
      // one long stretch with no idling on either side
      if (words_sent > 250 && words_sent < 400) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      pick = $urandom_range(99);
      n = $urandom_range(0, 10);
      if (pick < 70) begin
        repeat (n) send_char();
      end else if (pick < 80) begin
        repeat (n / 2) send_char();
        if ($urandom_range(1) == 0) begin
          send_byte(8'hc0 | 8'($urandom_range(0, 31)));
        end else begin
          send_byte(8'he0 | 8'($urandom_range(0, 15)));
          if ($urandom_range(1) == 0)
            send_cont();
        end
      end else if (pick < 90) begin
        repeat (n / 2) send_char();
        send_bad_lead();
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
      end else begin
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(8'h00);
      if ($urandom_range(99) < 4)
        wait_drain();
    end
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
    wait_drain();
  endtask

  initial begin
    clear_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_strings();

    wait_drain();
    $display("decoded %0d bytes, checked %0d result words, %0d mismatches",
             words_sent, results_checked, mismatches);
    $display("covered 1/2/3-byte chars, bad leads, truncation, halt and stall recovery");
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
